### src/tdmc_pkg.sv
// Shared types and codes for the two-level direct-mapped cache.
// No dependencies.
package tdmc_pkg;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;

	localparam logic [1:0] L2_NONE = 2'd0;
	localparam logic [1:0] L2_HIT  = 2'd1;
	localparam logic [1:0] L2_MISS = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] addr;
		logic [31:0] data;
		logic        ld_ok;
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TAG,
		ST_HITRD,
		ST_COPY,
		ST_RESP
	} st_t;

endpackage

### src/two_level_direct_mapped_cache.sv
// Two-level direct-mapped cache, top level. Depends on tdmc_pkg,
// tdmc_front and tdmc_back.
// Path of an operation: a load or unused command goes straight to the result;
// an L1 write hit writes L1 at the tag lookup, an L1 read hit then reads L1,
// and an L1 miss first fills the line word by word. The back end takes the
// next operation only after the result word is loaded. Reset: asynchronous;
// afterwards a clearing pass zeroes tags and backing memory while full is high.
module two_level_direct_mapped_cache #(
	parameter int OFFSET_WIDTH  = 2,
	parameter int FIRST_SETS    = 16,
	parameter int SECOND_SETS   = 64,
	parameter int BACKING_WORDS = 1024,
	parameter int ADDRESS_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         cmd,
	input  logic [15:0]        address,
	input  logic signed [31:0] write_data,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] read_data,
	output logic               l1_hit,
	output logic [1:0]         l2_outcome
);

	logic          clearing;
	logic          q_valid;
	logic          q_take;
	tdmc_pkg::op_t q_op;

	tdmc_front #(
		.BACKING_WORDS(BACKING_WORDS),
		.ADDRESS_WIDTH(ADDRESS_WIDTH)
	) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.address(address), .write_data(write_data), .clearing(clearing),
		.q_valid(q_valid), .q_op(q_op), .q_take(q_take)
	);

	tdmc_back #(
		.OFFSET_WIDTH(OFFSET_WIDTH),
		.FIRST_SETS(FIRST_SETS),
		.SECOND_SETS(SECOND_SETS),
		.BACKING_WORDS(BACKING_WORDS),
		.ADDRESS_WIDTH(ADDRESS_WIDTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .clearing(clearing), .q_valid(q_valid),
		.q_op(q_op), .q_take(q_take), .empty(empty), .pop(pop),
		.read_data(read_data), .l1_hit(l1_hit), .l2_outcome(l2_outcome)
	);

endmodule

### src/tdmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdmc_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/tdmc_front.sv
// Front end: accepts words, masks the address, flags loads in range and
// queues decoded operations in a two-entry queue. Depends on tdmc_pkg.
module tdmc_front #(
	parameter int BACKING_WORDS = 1024,
	parameter int ADDRESS_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          cmd,
	input  logic [15:0]         address,
	input  logic signed [31:0]  write_data,
	input  logic                clearing,
	output logic                q_valid,
	output tdmc_pkg::op_t       q_op,
	input  logic                q_take
);

	tdmc_pkg::op_t ent_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          push_ok;
	logic [31:0]   amask;
	tdmc_pkg::op_t new_op;

	assign full    = clearing || (cnt_q == 2'd2);
	assign push_ok = push && !full;
	assign q_valid = (cnt_q != 2'd0);
	assign q_op    = ent_q[rp_q];
	assign amask   = (ADDRESS_WIDTH >= 32) ? 32'hFFFF_FFFF
		: ((32'd1 << ADDRESS_WIDTH) - 32'd1);

	always_comb begin
		new_op.cmd   = cmd;
		new_op.addr  = {16'd0, address} & amask;
		new_op.data  = write_data;
		new_op.ld_ok = (({16'd0, address} & amask) < 32'(BACKING_WORDS));
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			ent_q[wp_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_ok) begin
				wp_q <= !wp_q;
			end
			if (q_take) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push_ok} - {1'b0, q_take};
		end
	end

endmodule

### src/tdmc_back.sv
// Back end: clears tags and backing memory after reset, looks up both
// levels, fills lines word by word and holds the result word.
// Depends on tdmc_pkg and tdmc_ram.
module tdmc_back #(
	parameter int OFFSET_WIDTH  = 2,
	parameter int FIRST_SETS    = 16,
	parameter int SECOND_SETS   = 64,
	parameter int BACKING_WORDS = 1024,
	parameter int ADDRESS_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	output logic               clearing,
	input  logic               q_valid,
	input  tdmc_pkg::op_t      q_op,
	output logic               q_take,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] read_data,
	output logic               l1_hit,
	output logic [1:0]         l2_outcome
);

	localparam int LW    = 1 << OFFSET_WIDTH;
	localparam int L1B   = (FIRST_SETS > 1) ? $clog2(FIRST_SETS) : 0;
	localparam int L2B   = (SECOND_SETS > 1) ? $clog2(SECOND_SETS) : 0;
	localparam int T1A   = (FIRST_SETS > 1) ? $clog2(FIRST_SETS) : 1;
	localparam int T2A   = (SECOND_SETS > 1) ? $clog2(SECOND_SETS) : 1;
	localparam int D1A   = (FIRST_SETS * LW > 1) ? $clog2(FIRST_SETS * LW) : 1;
	localparam int D2A   = (SECOND_SETS * LW > 1) ? $clog2(SECOND_SETS * LW) : 1;
	localparam int BKA   = (BACKING_WORDS > 1) ? $clog2(BACKING_WORDS) : 1;
	localparam int TW    = ADDRESS_WIDTH + 1;
	localparam int CLR_N = (BACKING_WORDS > SECOND_SETS)
		? ((BACKING_WORDS > FIRST_SETS) ? BACKING_WORDS : FIRST_SETS)
		: ((SECOND_SETS > FIRST_SETS) ? SECOND_SETS : FIRST_SETS);
	localparam int CW    = $clog2(CLR_N) + 1;
	localparam logic [OFFSET_WIDTH:0] LW_C = (OFFSET_WIDTH + 1)'(LW);

	tdmc_pkg::st_t st_q, st_d;
	tdmc_pkg::op_t op_q;
	logic [CW-1:0]           clr_q;
	logic [OFFSET_WIDTH:0]   cnt_q;
	logic                    in_q;
	logic [31:0]             rd_q;
	logic                    hit_q;
	logic [1:0]              l2_q;
	logic                    out_v_q;
	logic [31:0]             out_rd_q;
	logic                    out_hit_q;
	logic [1:0]              out_l2_q;

	logic [31:0] look_a, i1, t1, i2, t2, off, base, bk_a, w32, clr32;
	logic [OFFSET_WIDTH:0] w;
	logic        l1_match, l2_match, out_load;
	logic [31:0] src;

	logic           l1t_we, l2t_we, l1d_we, l2d_we, bk_we;
	logic [T1A-1:0] l1t_wa, l1t_ra;
	logic [T2A-1:0] l2t_wa, l2t_ra;
	logic [TW-1:0]  l1t_wd, l2t_wd, l1t_rd, l2t_rd;
	logic [D1A-1:0] l1d_wa, l1d_ra;
	logic [D2A-1:0] l2d_wa, l2d_ra;
	logic [31:0]    l1d_wd, l2d_wd, l1d_rd, l2d_rd;
	logic [BKA-1:0] bk_wa, bk_ra;
	logic [31:0]    bk_wd, bk_rd;

	assign look_a   = (st_q == tdmc_pkg::ST_IDLE) ? q_op.addr : op_q.addr;
	assign i1       = (look_a >> OFFSET_WIDTH) & 32'(FIRST_SETS - 1);
	assign t1       = look_a >> (OFFSET_WIDTH + L1B);
	assign i2       = (look_a >> OFFSET_WIDTH) & 32'(SECOND_SETS - 1);
	assign t2       = look_a >> (OFFSET_WIDTH + L2B);
	assign off      = look_a & 32'(LW - 1);
	assign base     = look_a & ~32'(LW - 1);
	assign bk_a     = base + 32'(cnt_q);
	assign w        = cnt_q - (OFFSET_WIDTH + 1)'(1);
	assign w32      = 32'(w);
	assign clr32    = 32'(clr_q);
	assign l1_match = l1t_rd[TW-1] && (l1t_rd[TW-2:0] == t1[ADDRESS_WIDTH-1:0]);
	assign l2_match = l2t_rd[TW-1] && (l2t_rd[TW-2:0] == t2[ADDRESS_WIDTH-1:0]);
	assign src      = (l2_q == tdmc_pkg::L2_MISS) ? (in_q ? bk_rd : 32'd0) : l2d_rd;
	assign out_load = (st_q == tdmc_pkg::ST_RESP) && (!out_v_q || pop);
	assign clearing = (st_q == tdmc_pkg::ST_CLEAR);

	assign empty      = !out_v_q;
	assign read_data  = out_rd_q;
	assign l1_hit     = out_hit_q;
	assign l2_outcome = out_l2_q;

	always_comb begin
		st_d   = st_q;
		q_take = 1'b0;
		l1t_we = 1'b0;
		l2t_we = 1'b0;
		l1d_we = 1'b0;
		l2d_we = 1'b0;
		bk_we  = 1'b0;
		l1t_wa = i1[T1A-1:0];
		l1t_wd = {1'b1, t1[ADDRESS_WIDTH-1:0]};
		l2t_wa = i2[T2A-1:0];
		l2t_wd = {1'b1, t2[ADDRESS_WIDTH-1:0]};
		l1t_ra = i1[T1A-1:0];
		l2t_ra = i2[T2A-1:0];
		l1d_wa = D1A'((i1 << OFFSET_WIDTH) | w32);
		l1d_wd = ((op_q.cmd == tdmc_pkg::CMD_WRITE) && (w32 == off)) ? op_q.data : src;
		l1d_ra = D1A'((i1 << OFFSET_WIDTH) | off);
		l2d_wa = D2A'((i2 << OFFSET_WIDTH) | w32);
		l2d_wd = src;
		l2d_ra = D2A'((i2 << OFFSET_WIDTH) | 32'(cnt_q));
		bk_wa  = q_op.addr[BKA-1:0];
		bk_wd  = q_op.data;
		bk_ra  = bk_a[BKA-1:0];
		case (st_q)
			tdmc_pkg::ST_CLEAR: begin
				bk_we  = clr32 < 32'(BACKING_WORDS);
				l2t_we = clr32 < 32'(SECOND_SETS);
				l1t_we = clr32 < 32'(FIRST_SETS);
				bk_wa  = clr32[BKA-1:0];
				bk_wd  = 32'd0;
				l2t_wa = clr32[T2A-1:0];
				l2t_wd = '0;
				l1t_wa = clr32[T1A-1:0];
				l1t_wd = '0;
				if (clr32 == 32'(CLR_N - 1)) begin
					st_d = tdmc_pkg::ST_IDLE;
				end
			end
			tdmc_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_take = 1'b1;
					if (q_op.cmd == tdmc_pkg::CMD_LOAD) begin
						bk_we = q_op.ld_ok;
						st_d  = tdmc_pkg::ST_RESP;
					end else if (q_op.cmd == tdmc_pkg::CMD_READ ||
						q_op.cmd == tdmc_pkg::CMD_WRITE) begin
						st_d = tdmc_pkg::ST_TAG;
					end else begin
						st_d = tdmc_pkg::ST_RESP;
					end
				end
			end
			tdmc_pkg::ST_TAG: begin
				if (l1_match) begin
					if (op_q.cmd == tdmc_pkg::CMD_WRITE) begin
						l1d_we = 1'b1;
						l1d_wa = l1d_ra;
						l1d_wd = op_q.data;
						st_d   = tdmc_pkg::ST_RESP;
					end else begin
						st_d = tdmc_pkg::ST_HITRD;
					end
				end else begin
					l1t_we = 1'b1;
					l2t_we = !l2_match;
					st_d   = tdmc_pkg::ST_COPY;
				end
			end
			tdmc_pkg::ST_HITRD: begin
				st_d = tdmc_pkg::ST_RESP;
			end
			tdmc_pkg::ST_COPY: begin
				if (cnt_q != '0) begin
					l1d_we = 1'b1;
					l2d_we = (l2_q == tdmc_pkg::L2_MISS);
				end
				if (cnt_q == LW_C) begin
					st_d = tdmc_pkg::ST_RESP;
				end
			end
			tdmc_pkg::ST_RESP: begin
				if (out_load) begin
					st_d = tdmc_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = tdmc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= tdmc_pkg::ST_CLEAR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == tdmc_pkg::ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			tdmc_pkg::ST_IDLE: begin
				op_q  <= q_op;
				rd_q  <= 32'd0;
				hit_q <= 1'b0;
				l2_q  <= tdmc_pkg::L2_NONE;
			end
			tdmc_pkg::ST_TAG: begin
				cnt_q <= '0;
				if (l1_match) begin
					hit_q <= 1'b1;
				end else begin
					l2_q <= l2_match ? tdmc_pkg::L2_HIT : tdmc_pkg::L2_MISS;
				end
			end
			tdmc_pkg::ST_HITRD: begin
				rd_q <= l1d_rd;
			end
			tdmc_pkg::ST_COPY: begin
				cnt_q <= cnt_q + (OFFSET_WIDTH + 1)'(1);
				in_q  <= bk_a < 32'(BACKING_WORDS);
				if (cnt_q != '0 && op_q.cmd == tdmc_pkg::CMD_READ && w32 == off) begin
					rd_q <= src;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_rd_q  <= rd_q;
			out_hit_q <= hit_q;
			out_l2_q  <= l2_q;
		end
	end

	tdmc_ram #(.DATA_W(TW), .DEPTH(FIRST_SETS)) u_l1t (
		.clk(clk), .we(l1t_we), .waddr(l1t_wa), .wdata(l1t_wd),
		.raddr(l1t_ra), .rdata(l1t_rd)
	);

	tdmc_ram #(.DATA_W(TW), .DEPTH(SECOND_SETS)) u_l2t (
		.clk(clk), .we(l2t_we), .waddr(l2t_wa), .wdata(l2t_wd),
		.raddr(l2t_ra), .rdata(l2t_rd)
	);

	tdmc_ram #(.DATA_W(32), .DEPTH(FIRST_SETS * LW)) u_l1d (
		.clk(clk), .we(l1d_we), .waddr(l1d_wa), .wdata(l1d_wd),
		.raddr(l1d_ra), .rdata(l1d_rd)
	);

	tdmc_ram #(.DATA_W(32), .DEPTH(SECOND_SETS * LW)) u_l2d (
		.clk(clk), .we(l2d_we), .waddr(l2d_wa), .wdata(l2d_wd),
		.raddr(l2d_ra), .rdata(l2d_rd)
	);

	tdmc_ram #(.DATA_W(32), .DEPTH(BACKING_WORDS)) u_bk (
		.clk(clk), .we(bk_we), .waddr(bk_wa), .wdata(bk_wd),
		.raddr(bk_ra), .rdata(bk_rd)
	);

endmodule

### src/tdmc_chk.sv
// Port-level checker for the two-level direct-mapped cache, bound to the
// top level. Depends on two_level_direct_mapped_cache.
module tdmc_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic signed [31:0] read_data,
	input logic               l1_hit,
	input logic [1:0]         l2_outcome
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result word dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(read_data))
		else $error("stalled read data changed");

	a_hit_no_l2: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && l1_hit) |-> (l2_outcome == 2'd0))
		else $error("L2 consulted on L1 hit");

	a_l2_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (l2_outcome != 2'd3))
		else $error("undefined L2 outcome");

endmodule

bind two_level_direct_mapped_cache tdmc_chk u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.read_data(read_data), .l1_hit(l1_hit), .l2_outcome(l2_outcome)
);
